// File: rtl/core/bmh_pkg.sv
// Shared constants, codes and controller/datapath interface types for the min-heap core.
`default_nettype none
package bmh_pkg;

  localparam int HEAP_DEPTH_DEF = 256;
  localparam int KEY_W          = 32;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 9;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_BUILD  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_ROOT_LAST = 2'd0,
    RD_BUILD     = 2'd1,
    RD_KIDS      = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_APPEND    = 2'd0,
    WR_NODE_VAL  = 2'd1,
    WR_NODE_PICK = 2'd2
  } wr_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_MAX  = 2'd1,
    RES_ROOT = 2'd2
  } res_sel_t;

  typedef enum logic [1:0] {
    NODE_ROOT  = 2'd0,
    NODE_BUILD = 2'd1,
    NODE_PICK  = 2'd2
  } node_sel_t;

  typedef enum logic {
    VAL_A = 1'b0,
    VAL_B = 1'b1
  } val_sel_t;

  typedef struct packed {
    logic      load_key;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      build_init;
    logic      build_dec;
    logic      node_load;
    node_sel_t node_sel;
    logic      val_load;
    val_sel_t  val_sel;
    logic      res_set;
    res_sel_t  res_sel;
    status_t   res_status;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic build_zero;
    logic is_leaf;
    logic child_less;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/bmh_datapath.sv
// Heap datapath: key store, fill count, sift registers and result registers.
`default_nettype none
module bmh_datapath #(
  parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [bmh_pkg::KEY_W-1:0]     key_in,
  input  wire bmh_pkg::cmd_t                        cmd,
  output bmh_pkg::sts_t                             sts,
  output logic signed [bmh_pkg::KEY_W-1:0]          out_min_key,
  output logic [bmh_pkg::STATUS_W-1:0]              out_status,
  output logic [bmh_pkg::COUNT_W-1:0]               out_entry_count
);

  localparam int AW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int IW    = AW + 2;
  localparam int EXT_W = CNT_W + bmh_pkg::COUNT_W;

  logic signed [bmh_pkg::KEY_W-1:0] mem [HEAP_DEPTH];

  logic signed [bmh_pkg::KEY_W-1:0] rd_a_r, rd_b_r;
  logic signed [bmh_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [bmh_pkg::KEY_W-1:0] val_r, val_nxt;
  logic signed [bmh_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic [bmh_pkg::STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic signed [bmh_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [bmh_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [bmh_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic [CNT_W-1:0]                 fill_r, fill_nxt;
  logic [CNT_W-1:0]                 bi_r, bi_nxt;
  logic [AW-1:0]                    node_r, node_nxt;

  logic [CNT_W-1:0]                 bi_m1;
  logic [CNT_W-1:0]                 last_idx;
  logic [IW-1:0]                    left_w, right_w, fill_w;
  logic                             right_ok;
  logic signed [bmh_pkg::KEY_W-1:0] pick_key;
  logic [AW-1:0]                    pick_idx;
  logic [AW-1:0]                    rd_addr_a, rd_addr_b, wr_addr;
  logic signed [bmh_pkg::KEY_W-1:0] wr_data;
  logic [EXT_W-1:0]                 fill_ext;

  assign bi_m1    = bi_r - CNT_W'(1);
  assign last_idx = fill_r - CNT_W'(1);
  assign left_w   = IW'({node_r, 1'b1});
  assign right_w  = left_w + IW'(1);
  assign fill_w   = IW'(fill_r);
  assign right_ok = (right_w < fill_w) && (rd_b_r < rd_a_r);
  assign pick_key = right_ok ? rd_b_r : rd_a_r;
  assign pick_idx = right_ok ? right_w[AW-1:0] : left_w[AW-1:0];
  assign fill_ext = EXT_W'(fill_r);

  assign sts.empty      = (fill_r == '0);
  assign sts.full       = (fill_r == CNT_W'(HEAP_DEPTH));
  assign sts.build_zero = (bi_r == '0);
  assign sts.is_leaf    = (left_w >= fill_w);
  assign sts.child_less = (pick_key < val_r);

  always_comb begin
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (cmd.rd_sel)
      bmh_pkg::RD_ROOT_LAST: begin
        rd_addr_b = last_idx[AW-1:0];
      end
      bmh_pkg::RD_BUILD: begin
        rd_addr_a = bi_m1[AW-1:0];
      end
      bmh_pkg::RD_KIDS: begin
        rd_addr_a = left_w[AW-1:0];
        rd_addr_b = right_w[AW-1:0];
      end
      default: begin
        rd_addr_a = '0;
      end
    endcase
  end

  always_comb begin
    wr_addr = node_r;
    wr_data = val_r;
    case (cmd.wr_sel)
      bmh_pkg::WR_APPEND: begin
        wr_addr = fill_r[AW-1:0];
        wr_data = key_r;
      end
      bmh_pkg::WR_NODE_PICK: begin
        wr_data = pick_key;
      end
      default: begin
        wr_data = val_r;
      end
    endcase
  end

  always_comb begin
    key_nxt        = cmd.load_key ? key_in : key_r;
    fill_nxt       = fill_r;
    bi_nxt         = bi_r;
    node_nxt       = node_r;
    val_nxt        = val_r;
    res_key_nxt    = res_key_r;
    res_status_nxt = res_status_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    if (cmd.cnt_inc) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      fill_nxt = last_idx;
    end
    if (cmd.build_init) begin
      bi_nxt = fill_r >> 1;
    end else if (cmd.build_dec) begin
      bi_nxt = bi_m1;
    end
    if (cmd.node_load) begin
      case (cmd.node_sel)
        bmh_pkg::NODE_BUILD: node_nxt = bi_m1[AW-1:0];
        bmh_pkg::NODE_PICK:  node_nxt = pick_idx;
        default:             node_nxt = '0;
      endcase
    end
    if (cmd.val_load) begin
      val_nxt = (cmd.val_sel == bmh_pkg::VAL_B) ? rd_b_r : rd_a_r;
    end
    if (cmd.res_set) begin
      res_status_nxt = cmd.res_status;
      case (cmd.res_sel)
        bmh_pkg::RES_MAX:  res_key_nxt = bmh_pkg::KEY_MAX;
        bmh_pkg::RES_ROOT: res_key_nxt = rd_a_r;
        default:           res_key_nxt = '0;
      endcase
    end
    if (cmd.emit) begin
      out_key_nxt    = res_key_r;
      out_status_nxt = res_status_r;
      out_count_nxt  = fill_ext[bmh_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bi_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      bi_r   <= bi_nxt;
    end
    key_r        <= key_nxt;
    node_r       <= node_nxt;
    val_r        <= val_nxt;
    res_key_r    <= res_key_nxt;
    res_status_r <= res_status_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_min_key     = out_key_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HEAP_DEPTH))
    else $error("fill count above heap depth");
  a_append_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("append did not advance fill count by one");
`endif

endmodule
`default_nettype wire

// File: rtl/core/bmh_ctrl.sv
// Heap controller: sequences append, build, remove and peek over the datapath.
`default_nettype none
module bmh_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bmh_pkg::OP_W-1:0]      op_in,
  input  wire bmh_pkg::sts_t                 sts,
  output bmh_pkg::cmd_t                      cmd,
  output logic                               busy,
  output logic                               out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PEEK_LOAD,
    S_REM_LOAD,
    S_BUILD_STEP,
    S_BUILD_LOAD,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  bmh_pkg::op_t    op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;
  state_t          sift_exit;

  assign sift_exit = (op_r == bmh_pkg::OP_BUILD) ? S_BUILD_STEP : S_DONE;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_key = 1'b1;
          op_nxt       = bmh_pkg::op_t'(op_in);
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_r)
          bmh_pkg::OP_APPEND: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = bmh_pkg::RES_ZERO;
            if (sts.full) begin
              cmd.res_status = bmh_pkg::ST_FULL;
            end else begin
              cmd.res_status = bmh_pkg::ST_OK;
              cmd.wr_en      = 1'b1;
              cmd.wr_sel     = bmh_pkg::WR_APPEND;
              cmd.cnt_inc    = 1'b1;
            end
            state_nxt = S_DONE;
          end
          bmh_pkg::OP_BUILD: begin
            cmd.build_init = 1'b1;
            state_nxt      = S_BUILD_STEP;
          end
          bmh_pkg::OP_REMOVE, bmh_pkg::OP_PEEK: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_sel    = bmh_pkg::RES_MAX;
              cmd.res_status = bmh_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = bmh_pkg::RD_ROOT_LAST;
              state_nxt  = (op_r == bmh_pkg::OP_REMOVE) ? S_REM_LOAD : S_PEEK_LOAD;
            end
          end
        endcase
      end
      S_PEEK_LOAD: begin
        cmd.res_set    = 1'b1;
        cmd.res_sel    = bmh_pkg::RES_ROOT;
        cmd.res_status = bmh_pkg::ST_OK;
        state_nxt      = S_DONE;
      end
      S_REM_LOAD: begin
        cmd.res_set    = 1'b1;
        cmd.res_sel    = bmh_pkg::RES_ROOT;
        cmd.res_status = bmh_pkg::ST_OK;
        cmd.val_load   = 1'b1;
        cmd.val_sel    = bmh_pkg::VAL_B;
        cmd.node_load  = 1'b1;
        cmd.node_sel   = bmh_pkg::NODE_ROOT;
        cmd.cnt_dec    = 1'b1;
        state_nxt      = S_SIFT_RD;
      end
      S_BUILD_STEP: begin
        if (sts.build_zero) begin
          cmd.res_set    = 1'b1;
          cmd.res_sel    = bmh_pkg::RES_ZERO;
          cmd.res_status = bmh_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else begin
          cmd.build_dec = 1'b1;
          cmd.node_load = 1'b1;
          cmd.node_sel  = bmh_pkg::NODE_BUILD;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = bmh_pkg::RD_BUILD;
          state_nxt     = S_BUILD_LOAD;
        end
      end
      S_BUILD_LOAD: begin
        cmd.val_load = 1'b1;
        cmd.val_sel  = bmh_pkg::VAL_A;
        state_nxt    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        if (sts.is_leaf) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = bmh_pkg::WR_NODE_VAL;
          state_nxt  = sift_exit;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bmh_pkg::RD_KIDS;
          state_nxt  = S_SIFT_CMP;
        end
      end
      S_SIFT_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.child_less) begin
          cmd.wr_sel    = bmh_pkg::WR_NODE_PICK;
          cmd.node_load = 1'b1;
          cmd.node_sel  = bmh_pkg::NODE_PICK;
          state_nxt     = S_SIFT_RD;
        end else begin
          cmd.wr_sel = bmh_pkg::WR_NODE_VAL;
          state_nxt  = sift_exit;
        end
      end
      S_DONE: begin
        cmd.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");
`endif

endmodule
`default_nettype wire

// File: rtl/core/binary_min_heap_core.sv
// Top level of the binary min-heap core: controller plus datapath.
//
// Usage:
//   Input channel: drive in_op and in_key_in and raise start; the item is
//   taken at a rising edge with start high and busy low. Ops: append key,
//   build heap, remove minimum, peek minimum.
//   Result channel: out_valid pulses for one cycle with out_min_key,
//   out_status and out_entry_count; the receiver cannot stall it.
//   Steps after the accepting edge: append runs decode, then done; peek
//   runs decode, a root read and done; remove or peek on an empty heap
//   runs decode and done; remove runs decode, a read of root and last
//   entry, a sift down from the root and done; build runs decode, a sift
//   of each internal node from the last one back to the root, then done.
//   busy drops in the cycle the result shows, so the next item may be
//   taken then. Each sift level is a registered two-port read of both
//   children, then a compare and a single write back to the key store.
//   Reset: synchronous, active low; empties the heap and returns to idle.
//   Store contents are not cleared, only the fill count.
`default_nettype none
module binary_min_heap_core #(
  parameter int HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [bmh_pkg::OP_W-1:0]             in_op,
  input  wire logic signed [bmh_pkg::KEY_W-1:0]     in_key_in,
  output logic                                      out_valid,
  output logic signed [bmh_pkg::KEY_W-1:0]          out_min_key,
  output logic [bmh_pkg::STATUS_W-1:0]              out_status,
  output logic [bmh_pkg::COUNT_W-1:0]               out_entry_count
);

  bmh_pkg::cmd_t cmd;
  bmh_pkg::sts_t sts;

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_in     (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bmh_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_in          (in_key_in),
    .cmd             (cmd),
    .sts             (sts),
    .out_min_key     (out_min_key),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire
